[rtl/core/fixed_width_include_lint_scan_core_assert.svh]
// assertion macros shared by the lint scanner rtl
`ifndef FIXED_WIDTH_INCLUDE_LINT_SCAN_CORE_ASSERT_SVH
`define FIXED_WIDTH_INCLUDE_LINT_SCAN_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FWILS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fwils assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define FWILS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fwils assertion failed");

`endif

[rtl/core/fwils_pkg.sv]
// shared types and constants for the fixed-width include lint scanner
package fwils_pkg;

	localparam int LINE_W = 24;
	localparam logic [LINE_W-1:0] LINE_LIMIT = {LINE_W{1'b1}};

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// up to three stripped bytes per step, emitted slot 0 first
	typedef struct packed {
		logic [2:0]      vld;
		logic [2:0][7:0] ch;
	} emit_seq_t;

	typedef struct packed {
		logic              missing;
		logic [3:0]        idx;
		logic [LINE_W-1:0] line;
		logic              inc;
	} verdict_t;

endpackage

[rtl/core/fwils_byte_if.sv]
// byte input channel of the lint scanner
interface fwils_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_byte;
	logic       last_byte;

	modport source (output valid, output src_byte, output last_byte, input ready);
	modport sink (input valid, input src_byte, input last_byte, output ready);
endinterface

[rtl/core/fwils_verdict_if.sv]
// verdict output channel of the lint scanner
interface fwils_verdict_if import fwils_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              missing_include;
	logic [3:0]        type_index;
	logic [LINE_W-1:0] line_number;
	logic              include_present;

	modport source (output valid, output missing_include, output type_index,
		output line_number, output include_present, input ready);
	modport sink (input valid, input missing_include, input type_index,
		input line_number, input include_present, output ready);
endinterface

[rtl/core/fwils_lexer.sv]
// comment and literal stripper: lexer mode register and emitted bytes
module fwils_lexer import fwils_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] c,
	input  logic       last,
	output emit_seq_t  seq
);

	typedef enum logic [8:0] {
		M_CODE    = 9'b000000001,
		M_SLASH   = 9'b000000010,
		M_LINE    = 9'b000000100,
		M_BLOCK   = 9'b000001000,
		M_STAR    = 9'b000010000,
		M_STR     = 9'b000100000,
		M_STR_ESC = 9'b001000000,
		M_CHR     = 9'b010000000,
		M_CHR_ESC = 9'b100000000
	} lex_mode_t;

	lex_mode_t mode_q;
	lex_mode_t em;
	lex_mode_t nm;
	logic      done;

	always_comb begin
		seq  = '0;
		em   = mode_q;
		nm   = mode_q;
		done = 1'b0;

		// held slash or star resolves against this byte
		unique case (mode_q)
			M_SLASH: begin
				if (c == CH_SLASH || c == CH_STAR) begin
					seq.vld[1:0] = 2'b11;
					seq.ch[0]    = CH_SPACE;
					seq.ch[1]    = CH_SPACE;
					nm           = (c == CH_SLASH) ? M_LINE : M_BLOCK;
					done         = 1'b1;
				end else begin
					seq.vld[0] = 1'b1;
					seq.ch[0]  = CH_SLASH;
					em         = M_CODE;
				end
			end
			M_STAR: begin
				if (c == CH_SLASH) begin
					seq.vld[1:0] = 2'b11;
					seq.ch[0]    = CH_SPACE;
					seq.ch[1]    = CH_SPACE;
					nm           = M_CODE;
					done         = 1'b1;
				end else begin
					seq.vld[0] = 1'b1;
					seq.ch[0]  = CH_SPACE;
					em         = M_BLOCK;
				end
			end
			default: ;
		endcase

		if (!done) begin
			unique case (em)
				M_LINE: begin
					seq.vld[1] = 1'b1;
					seq.ch[1]  = (c == CH_NL) ? CH_NL : CH_SPACE;
					nm         = (c == CH_NL) ? M_CODE : M_LINE;
				end
				M_BLOCK: begin
					if (c == CH_STAR) begin
						nm = M_STAR;
					end else begin
						seq.vld[1] = 1'b1;
						seq.ch[1]  = (c == CH_NL) ? CH_NL : CH_SPACE;
						nm         = M_BLOCK;
					end
				end
				M_STR: begin
					seq.vld[1] = 1'b1;
					seq.ch[1]  = CH_SPACE;
					if (c == CH_BSLASH) begin
						nm = M_STR_ESC;
					end else if (c == CH_DQUOTE) begin
						nm = M_CODE;
					end else begin
						nm = M_STR;
					end
				end
				M_CHR: begin
					seq.vld[1] = 1'b1;
					seq.ch[1]  = CH_SPACE;
					if (c == CH_BSLASH) begin
						nm = M_CHR_ESC;
					end else if (c == CH_SQUOTE) begin
						nm = M_CODE;
					end else begin
						nm = M_CHR;
					end
				end
				M_STR_ESC: begin
					seq.vld[1] = 1'b1;
					seq.ch[1]  = CH_SPACE;
					nm         = M_STR;
				end
				M_CHR_ESC: begin
					seq.vld[1] = 1'b1;
					seq.ch[1]  = CH_SPACE;
					nm         = M_CHR;
				end
				default: begin
					// code mode, also any stray mode code
					if (c == CH_SLASH) begin
						nm = M_SLASH;
					end else if (c == CH_DQUOTE) begin
						seq.vld[1] = 1'b1;
						seq.ch[1]  = CH_SPACE;
						nm         = M_STR;
					end else if (c == CH_SQUOTE) begin
						seq.vld[1] = 1'b1;
						seq.ch[1]  = CH_SPACE;
						nm         = M_CHR;
					end else begin
						seq.vld[1] = 1'b1;
						seq.ch[1]  = c;
						nm         = M_CODE;
					end
				end
			endcase
		end

		// end of file flushes a held byte
		if (last) begin
			if (nm == M_SLASH) begin
				seq.vld[2] = 1'b1;
				seq.ch[2]  = CH_SLASH;
			end else if (nm == M_STAR) begin
				seq.vld[2] = 1'b1;
				seq.ch[2]  = CH_SPACE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_CODE;
		end else if (step) begin
			mode_q <= last ? M_CODE : nm;
		end
	end

endmodule

[rtl/core/fwils_scan.sv]
// stripped-text scanner: words, include window, line count, verdict
module fwils_scan import fwils_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      last,
	input  emit_seq_t seq,
	output verdict_t  vd
);

	localparam int TYPE_N = 10;
	localparam logic [3:0] WORD_MAX = 4'd9;

	// watched names, right aligned and zero padded, in list order
	localparam logic [71:0] TYPE_NAME [TYPE_N] = '{
		72'({"uint8", "_t"}), 72'({"uint16", "_t"}), 72'({"uint32", "_t"}),
		72'({"uint64", "_t"}), 72'({"int8", "_t"}), 72'({"int16", "_t"}),
		72'({"int32", "_t"}), 72'({"int64", "_t"}), 72'({"uintptr", "_t"}),
		72'({"intptr", "_t"})
	};
	localparam logic [3:0] TYPE_LEN [TYPE_N] = '{
		4'd7, 4'd8, 4'd8, 4'd8, 4'd6, 4'd7, 4'd7, 4'd7, 4'd9, 4'd8
	};
	localparam logic [71:0] INC_SHORT = "<cstdint>";
	localparam logic [79:0] INC_LONG  = "<stdint.h>";

	typedef struct packed {
		logic [71:0]                    win;
		logic [71:0]                    word;
		logic [3:0]                     wlen;
		logic                           too_long;
		logic                           inc;
		logic [LINE_W-1:0]              line;
		logic [TYPE_N-1:0]              seen;
		logic [TYPE_N-1:0][LINE_W-1:0]  first;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		win: {9{CH_SPACE}}, word: '0, wlen: '0, too_long: 1'b0, inc: 1'b0,
		line: LINE_W'(1), seen: '0, first: '0
	};

	function automatic logic is_ident(input logic [7:0] ch);
		return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
			(ch >= 8'h30 && ch <= 8'h39) || ch == 8'h5F;
	endfunction

	// word buffer is zeroed here, so a plain compare against the padded name works
	function automatic scan_t close_word(input scan_t s);
		scan_t r;
		r = s;
		if (!s.too_long && s.wlen != 4'd0) begin
			for (int t = 0; t < TYPE_N; t++) begin
				if (s.word == TYPE_NAME[t] && s.wlen == TYPE_LEN[t] && !s.seen[t]) begin
					r.seen[t]  = 1'b1;
					r.first[t] = s.line;
				end
			end
		end
		r.word     = '0;
		r.wlen     = '0;
		r.too_long = 1'b0;
		return r;
	endfunction

	function automatic scan_t emit_ch(input scan_t s, input logic [7:0] ch);
		scan_t r;
		r = s;
		if ({s.win[63:0], ch} == INC_SHORT || {s.win, ch} == INC_LONG) begin
			r.inc = 1'b1;
		end
		r.win = {s.win[63:0], ch};
		if (is_ident(ch)) begin
			if (s.wlen < WORD_MAX) begin
				r.word = {s.word[63:0], ch};
				r.wlen = s.wlen + 4'd1;
			end else begin
				r.too_long = 1'b1;
			end
		end else begin
			r = close_word(r);
			if (ch == CH_NL && r.line != LINE_LIMIT) begin
				r.line = r.line + LINE_W'(1);
			end
		end
		return r;
	endfunction

	scan_t st_q;
	scan_t st_d;
	scan_t fin;

	always_comb begin
		st_d = st_q;
		for (int k = 0; k < 3; k++) begin
			if (seq.vld[k]) begin
				st_d = emit_ch(st_d, seq.ch[k]);
			end
		end
		fin = close_word(st_d);

		vd         = '0;
		vd.inc     = fin.inc;
		if (!fin.inc && fin.seen != '0) begin
			vd.missing = 1'b1;
			// lowest set index wins
			for (int t = TYPE_N - 1; t >= 0; t--) begin
				if (fin.seen[t]) begin
					vd.idx  = 4'(t);
					vd.line = fin.first[t];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SCAN_RESET;
		end else if (step) begin
			st_q <= last ? SCAN_RESET : st_d;
		end
	end

endmodule

[rtl/core/fixed_width_include_lint_scan_core.sv]
// path: an accepted byte waits in the input stage; a committed last byte loads the verdict register
// throughput: one byte per cycle while no last byte stalls; the stripper and scanner are a single registered pass
// a stalled verdict holds back only a following last byte, other bytes keep flowing
// reset: arst_n clears the input stage valid, verdict valid, lexer mode and scanner state
// after each verdict the scanner state returns to its reset values for the next file
`include "fixed_width_include_lint_scan_core_assert.svh"

module fixed_width_include_lint_scan_core import fwils_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	fwils_byte_if.sink        bytes,
	fwils_verdict_if.source   verdict
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// verdict register
	logic       res_valid_q;
	verdict_t   res_q;

	logic       advance;
	logic       step;
	emit_seq_t  seq;
	verdict_t   vd;

	// the staged byte can commit unless it closes a file and the previous verdict
	// still waits for its transfer
	assign advance     = !(last_s1 && res_valid_q && !verdict.ready);
	assign step        = valid_s1 && advance;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.src_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	// strips comments and literals into up to three bytes per step
	fwils_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (byte_s1),
		.last   (last_s1),
		.seq    (seq)
	);

	// watches stripped bytes and forms the end-of-file verdict
	fwils_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.last   (last_s1),
		.seq    (seq),
		.vd     (vd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= vd;
		end
	end

	assign verdict.valid           = res_valid_q;
	assign verdict.missing_include = res_q.missing;
	assign verdict.type_index      = res_q.idx;
	assign verdict.line_number     = res_q.line;
	assign verdict.include_present = res_q.inc;

	// a committed last byte always leaves a verdict behind
	`FWILS_ASSERT_NEXT(a_last_gives_verdict, step && last_s1, res_valid_q)
	// an include suppresses any flag
	`FWILS_ASSERT_NOW(a_inc_no_flag, res_valid_q && res_q.inc, !res_q.missing)
	// an unflagged verdict carries zero index and line
	`FWILS_ASSERT_NOW(a_clear_fields, res_valid_q && !res_q.missing,
		res_q.idx == 4'd0 && res_q.line == '0)
	// lines count from one, so a flagged use never reports line zero
	`FWILS_ASSERT_NOW(a_flag_line, res_valid_q && res_q.missing,
		res_q.line != '0 && res_q.idx <= 4'd9)
	// an empty input stage never backpressures
	`FWILS_ASSERT_NOW(a_ready_when_empty, !valid_s1, bytes.ready)

endmodule
